/* design/per_path_round_robin_send_scheduler_assert.svh */
// Assertion macros shared by the scheduler modules.
`ifndef PER_PATH_ROUND_ROBIN_SEND_SCHEDULER_ASSERT_SVH
`define PER_PATH_ROUND_ROBIN_SEND_SCHEDULER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PPSRR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PPSRR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ppsrr_pkg.sv */
package ppsrr_pkg;

   localparam int PATH_SLOTS  = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_BITS    = 32;
   localparam int SLOT_W      = $clog2(PATH_SLOTS);
   localparam int DEPTH_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = SLOT_W + DEPTH_W;
   localparam int SIZE_W      = $clog2(PATH_SLOTS + 1);
   localparam int HANDLE_W    = 16;
   localparam int KIND_W      = 2;
   localparam int EVENT_W     = 2;
   localparam int SENDS_W     = 6;
   localparam int LIMIT_W     = 4;
   localparam int CSR_DATA_W  = 6;
   localparam int SEND_CAP    = 32;

   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

   localparam logic [EVENT_W-1:0] EVENT_SEND   = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_REJECT = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_DONE   = 2'd2;

   localparam logic CSR_MAX_SENDS   = 1'b0;
   localparam logic CSR_QUEUE_LIMIT = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [TAG_BITS-1:0] tag;
      logic [HANDLE_W-1:0] msg;
      logic [HANDLE_W-1:0] rtr;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

/* design/per_path_round_robin_send_scheduler.sv */
// An enqueue walks look, decide and place, a remove look and decide; a reject is reported
// from decide. A tick clears marked paths, purges freed entries from the ring when paths
// were marked, sends the priority queue, then visits ring entries, empty ones too; each
// send has an emit state, so sends are never back to back. The back end is one sequencer.
// Reset is synchronous, active high: path table holds only the priority path, ring empty.
// Results cannot be stalled by the receiver.
module per_path_round_robin_send_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ppsrr_pkg::KIND_W-1:0]         req_kind,
   input  logic [ppsrr_pkg::TAG_BITS-1:0]       req_path_tag,
   input  logic [ppsrr_pkg::HANDLE_W-1:0]       req_message_handle,
   input  logic [ppsrr_pkg::HANDLE_W-1:0]       req_router_handle,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [ppsrr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                                 rsp_strobe,
   output logic [ppsrr_pkg::EVENT_W-1:0]        rsp_event_res,
   output logic [ppsrr_pkg::HANDLE_W-1:0]       rsp_message_handle_res,
   output logic [ppsrr_pkg::HANDLE_W-1:0]       rsp_router_handle_res,
   output logic                                 rsp_last
);
   import ppsrr_pkg::*;

   // The front end buffers up to two requests so that a new request can be taken
   // while the back end is still walking the ring for an earlier tick.
   item_type       req_item;
   queue_head_type q_head;
   logic           q_take;

   assign req_item.kind = req_kind;
   assign req_item.tag  = req_path_tag;
   assign req_item.msg  = req_message_handle;
   assign req_item.rtr  = req_router_handle;

   ppsrr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .head     (q_head),
      .take     (q_take)
   );

   // The back end owns the path table, the per-path queues and the ring, and
   // executes one request at a time.
   ppsrr_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (q_head),
      .take                   (q_take),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .rsp_strobe             (rsp_strobe),
      .rsp_event_res          (rsp_event_res),
      .rsp_message_handle_res (rsp_message_handle_res),
      .rsp_router_handle_res  (rsp_router_handle_res),
      .rsp_last               (rsp_last)
   );

endmodule

/* design/ppsrr_front.sv */
`include "per_path_round_robin_send_scheduler_assert.svh"

module ppsrr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ppsrr_pkg::item_type              req_item,
   output ppsrr_pkg::queue_head_type        head,
   input  logic                             take
);
   import ppsrr_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, take};
      end
   end

   `PPSRR_ASSERT_SAME(a_take_nonempty, take, cnt_ff != 2'd0, "take from empty queue")
   `PPSRR_ASSERT_SAME(a_cnt_range, 1'b1, cnt_ff != 2'd3, "queue count out of range")
   `PPSRR_ASSERT_NEXT(a_push_grows, push && !take, cnt_ff != 2'd0, "push lost")

endmodule

/* design/ppsrr_back.sv */
`include "per_path_round_robin_send_scheduler_assert.svh"

module ppsrr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppsrr_pkg::queue_head_type            head,
   output logic                                 take,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [ppsrr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                                 rsp_strobe,
   output logic [ppsrr_pkg::EVENT_W-1:0]        rsp_event_res,
   output logic [ppsrr_pkg::HANDLE_W-1:0]       rsp_message_handle_res,
   output logic [ppsrr_pkg::HANDLE_W-1:0]       rsp_router_handle_res,
   output logic                                 rsp_last
);
   import ppsrr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_DECIDE, S_PLACE, S_TICK_CLR, S_PURGE,
      S_PRIO, S_PRIO_EMIT, S_RING, S_RING_EMIT, S_DONE
   } state_type;

   state_type               state_ff;
   item_type                cur_ff;
   logic [PATH_SLOTS-1:0]   match_ff;
   logic [PATH_SLOTS-1:0]   free_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [PATH_SLOTS-1:0]   used_ff;
   logic [TAG_BITS-1:0]     path_ff [PATH_SLOTS];
   logic [PATH_SLOTS-1:0]   mark_ff;
   logic [DEPTH_W-1:0]      qhead_ff [PATH_SLOTS];
   logic [CNT_W-1:0]        qcnt_ff [PATH_SLOTS];
   logic [SLOT_W-1:0]       ring_ff [PATH_SLOTS];
   logic [SLOT_W-1:0]       front_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [SIZE_W-1:0]       laps_ff;
   logic [SIZE_W-1:0]       iter_ff;
   logic [SENDS_W-1:0]      sent_ff;
   logic [SIZE_W-1:0]       empty_ff;
   logic [SENDS_W-1:0]      max_sends_ff;
   logic [LIMIT_W-1:0]      qlimit_ff;
   logic                    strobe_ff;
   logic [EVENT_W-1:0]      event_ff;
   logic [HANDLE_W-1:0]     msg_ff;
   logic [HANDLE_W-1:0]     rtr_ff;
   logic                    last_ff;

   logic [2*HANDLE_W-1:0]   mem [PATH_SLOTS*QUEUE_DEPTH];
   logic [2*HANDLE_W-1:0]   rd_data_ff;
   logic                    mem_we;
   logic                    mem_re;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [ADDR_W-1:0]       mem_raddr;

   logic [PATH_SLOTS-1:0]   match_vec;
   logic [PATH_SLOTS-1:0]   free_vec;
   logic [SLOT_W-1:0]       match_idx;
   logic [SLOT_W-1:0]       free_idx;
   logic [SLOT_W-1:0]       sel;
   logic [SLOT_W-1:0]       ring_cur;
   logic [SLOT_W-1:0]       ring_tail;
   logic [DEPTH_W-1:0]      head_sel;
   logic [CNT_W-1:0]        cnt_sel;
   logic [LIMIT_W-1:0]      lim;
   logic [SENDS_W-1:0]      eff_limit;
   logic                    drop;

   assign take = (state_ff == S_IDLE) && head.valid;

   assign rsp_strobe             = strobe_ff;
   assign rsp_event_res          = event_ff;
   assign rsp_message_handle_res = msg_ff;
   assign rsp_router_handle_res  = rtr_ff;
   assign rsp_last               = last_ff;

   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int s = 0; s < PATH_SLOTS; s++) begin
         match_vec[s] = used_ff[s] && (path_ff[s] == cur_ff.tag);
         free_vec[s]  = (s != 0) && !used_ff[s];
         if (match_ff[s]) begin
            match_idx = match_idx | SLOT_W'(s);
         end
      end
      for (int s = PATH_SLOTS - 1; s > 0; s--) begin
         if (free_ff[s]) begin
            free_idx = SLOT_W'(s);
         end
      end
   end

   assign ring_cur  = ring_ff[front_ff];
   assign ring_tail = front_ff + size_ff[SLOT_W-1:0];

   always_comb begin
      unique case (state_ff)
         S_PLACE: sel = slot_ff;
         S_RING:  sel = ring_cur;
         default: sel = '0;
      endcase
   end

   assign head_sel = qhead_ff[sel];
   assign cnt_sel  = qcnt_ff[sel];

   always_comb begin
      if (qlimit_ff == '0) begin
         lim = LIMIT_W'(1);
      end else if (qlimit_ff > LIMIT_W'(QUEUE_DEPTH)) begin
         lim = LIMIT_W'(QUEUE_DEPTH);
      end else begin
         lim = qlimit_ff;
      end
      eff_limit = (max_sends_ff > SENDS_W'(SEND_CAP)) ? SENDS_W'(SEND_CAP) : max_sends_ff;
   end

   assign drop      = CNT_W'(cnt_sel) >= CNT_W'(lim);
   assign mem_we    = (state_ff == S_PLACE);
   assign mem_waddr = {slot_ff, head_sel + cnt_sel[DEPTH_W-1:0]};
   assign mem_re    = ((state_ff == S_PRIO) || (state_ff == S_RING)) && (cnt_sel != '0);
   assign mem_raddr = {sel, head_sel};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= {cur_ff.msg, cur_ff.rtr};
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= PATH_SLOTS'(1);
         mark_ff      <= '0;
         front_ff     <= '0;
         size_ff      <= '0;
         max_sends_ff <= SENDS_W'(16);
         qlimit_ff    <= LIMIT_W'(8);
         strobe_ff    <= 1'b0;
         last_ff      <= 1'b0;
         for (int s = 0; s < PATH_SLOTS; s++) begin
            path_ff[s]  <= '0;
            qhead_ff[s] <= '0;
            qcnt_ff[s]  <= '0;
         end
      end else begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         if (csr_write_enable) begin
            if (csr_index == CSR_MAX_SENDS) begin
               max_sends_ff <= csr_write_data;
            end else begin
               qlimit_ff <= csr_write_data[LIMIT_W-1:0];
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  cur_ff <= head.item;
                  if (head.item.kind == KIND_TICK) begin
                     state_ff <= S_TICK_CLR;
                  end else if (head.item.kind == KIND_ENQUEUE ||
                               head.item.kind == KIND_REMOVE) begin
                     state_ff <= S_LOOK;
                  end
               end
            end
            S_LOOK: begin
               match_ff <= match_vec;
               free_ff  <= free_vec;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (cur_ff.kind == KIND_REMOVE) begin
                  if (match_ff != '0) begin
                     mark_ff[match_idx] <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end else if (match_ff != '0) begin
                  slot_ff  <= match_idx;
                  state_ff <= S_PLACE;
               end else if (free_ff != '0) begin
                  slot_ff             <= free_idx;
                  used_ff[free_idx]   <= 1'b1;
                  path_ff[free_idx]   <= cur_ff.tag;
                  qhead_ff[free_idx]  <= '0;
                  qcnt_ff[free_idx]   <= '0;
                  mark_ff[free_idx]   <= 1'b0;
                  ring_ff[ring_tail]  <= free_idx;
                  size_ff             <= size_ff + SIZE_W'(1);
                  state_ff            <= S_PLACE;
               end else begin
                  // Path table full: the request comes back as a notice.
                  strobe_ff <= 1'b1;
                  event_ff  <= EVENT_REJECT;
                  msg_ff    <= cur_ff.msg;
                  rtr_ff    <= cur_ff.rtr;
                  last_ff   <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            S_PLACE: begin
               if (drop) begin
                  qhead_ff[slot_ff] <= head_sel + DEPTH_W'(1);
               end else begin
                  qcnt_ff[slot_ff] <= cnt_sel + CNT_W'(1);
               end
               state_ff <= S_IDLE;
            end
            S_TICK_CLR: begin
               for (int s = 0; s < PATH_SLOTS; s++) begin
                  if (mark_ff[s]) begin
                     qhead_ff[s] <= '0;
                     qcnt_ff[s]  <= '0;
                     if (s != 0) begin
                        used_ff[s] <= 1'b0;
                        path_ff[s] <= '0;
                     end
                  end
               end
               mark_ff  <= '0;
               laps_ff  <= size_ff;
               iter_ff  <= '0;
               state_ff <= ((mark_ff != '0) && (size_ff != '0)) ? S_PURGE : S_PRIO;
            end
            S_PURGE: begin
               if (used_ff[ring_cur]) begin
                  ring_ff[ring_tail] <= ring_cur;
               end else begin
                  size_ff <= size_ff - SIZE_W'(1);
               end
               front_ff <= front_ff + SLOT_W'(1);
               iter_ff  <= iter_ff + SIZE_W'(1);
               if (iter_ff + SIZE_W'(1) == laps_ff) begin
                  state_ff <= S_PRIO;
               end
            end
            S_PRIO: begin
               sent_ff  <= '0;
               empty_ff <= '0;
               if (cnt_sel != '0) begin
                  qhead_ff[0] <= head_sel + DEPTH_W'(1);
                  qcnt_ff[0]  <= cnt_sel - CNT_W'(1);
                  state_ff    <= S_PRIO_EMIT;
               end else if (size_ff != '0 && eff_limit != '0) begin
                  state_ff <= S_RING;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_PRIO_EMIT: begin
               strobe_ff <= 1'b1;
               event_ff  <= EVENT_SEND;
               msg_ff    <= rd_data_ff[2*HANDLE_W-1:HANDLE_W];
               rtr_ff    <= rd_data_ff[HANDLE_W-1:0];
               state_ff  <= S_PRIO;
            end
            S_RING: begin
               ring_ff[ring_tail] <= ring_cur;
               front_ff           <= front_ff + SLOT_W'(1);
               if (cnt_sel != '0) begin
                  qhead_ff[ring_cur] <= head_sel + DEPTH_W'(1);
                  qcnt_ff[ring_cur]  <= cnt_sel - CNT_W'(1);
                  sent_ff            <= sent_ff + SENDS_W'(1);
                  empty_ff           <= '0;
                  state_ff           <= S_RING_EMIT;
               end else if (empty_ff + SIZE_W'(1) == size_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  empty_ff <= empty_ff + SIZE_W'(1);
               end
            end
            S_RING_EMIT: begin
               strobe_ff <= 1'b1;
               event_ff  <= EVENT_SEND;
               msg_ff    <= rd_data_ff[2*HANDLE_W-1:HANDLE_W];
               rtr_ff    <= rd_data_ff[HANDLE_W-1:0];
               state_ff  <= (sent_ff == eff_limit) ? S_DONE : S_RING;
            end
            S_DONE: begin
               strobe_ff <= 1'b1;
               event_ff  <= EVENT_DONE;
               msg_ff    <= '0;
               rtr_ff    <= '0;
               last_ff   <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `PPSRR_ASSERT_SAME(a_ring_live, state_ff == S_RING, size_ff != '0, "ring visit on empty ring")
   `PPSRR_ASSERT_SAME(a_last_strobe, last_ff, strobe_ff, "last without result")
   `PPSRR_ASSERT_SAME(a_slot0_used, 1'b1, used_ff[0], "priority slot freed")
   `PPSRR_ASSERT_NEXT(a_done_idle, state_ff == S_DONE, state_ff == S_IDLE && last_ff, "tick hung")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

// Request-level testbench for the per-path round-robin send scheduler.
// A clocked driver takes requests from a queue that the initial block fills,
// one phase at a time. A clocked monitor checks every result strobe against
// the expectations that the scheduler model below produces when a request is
// accepted. Register writes only happen while the block is fully idle.
module tb;
   import ppsrr_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RUN_LIMIT = 400000;
   localparam int SETTLE = 80;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [TAG_BITS-1:0] tag;
      logic [HANDLE_W-1:0] msg;
      logic [HANDLE_W-1:0] rtr;
      int                  gap;
      bit                  drain;
   } request_type;

   typedef struct {
      logic [EVENT_W-1:0]  ev;
      logic [HANDLE_W-1:0] msg;
      logic [HANDLE_W-1:0] rtr;
      logic                last;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KIND_W-1:0] req_kind = '0;
   logic [TAG_BITS-1:0] req_path_tag = '0;
   logic [HANDLE_W-1:0] req_message_handle = '0;
   logic [HANDLE_W-1:0] req_router_handle = '0;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic rsp_strobe;
   logic [EVENT_W-1:0] rsp_event_res;
   logic [HANDLE_W-1:0] rsp_message_handle_res;
   logic [HANDLE_W-1:0] rsp_router_handle_res;
   logic rsp_last;

   per_path_round_robin_send_scheduler dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Scheduler model state, kept by the testbench itself.
   int sends_per_tick = 16;
   int length_limit = 8;
   bit path_live [PATH_SLOTS];
   logic [TAG_BITS-1:0] path_tag_of [PATH_SLOTS];
   bit drop_pending [PATH_SLOTS];
   logic [31:0] backlog [PATH_SLOTS][QUEUE_DEPTH];
   int backlog_head [PATH_SLOTS];
   int backlog_len [PATH_SLOTS];
   int rotation [PATH_SLOTS];
   int rot_front;
   int rot_size;

   request_type pending_requests [$];
   outcome_type awaited_results [$];
   request_type cur;
   int gap_left;
   int errors, accepted, results_seen, rejects_seen, ticks_seen, cycles;
   logic [TAG_BITS-1:0] tag_pool [24];

   function automatic int lookup_path(logic [TAG_BITS-1:0] tag);
      for (int s = 0; s < PATH_SLOTS; s++)
         if (path_live[s] && path_tag_of[s] == tag) return s;
      return -1;
   endfunction

   function automatic logic [31:0] pop_backlog(int s);
      logic [31:0] e;
      e = backlog[s][backlog_head[s]];
      backlog_head[s] = (backlog_head[s] + 1) % QUEUE_DEPTH;
      backlog_len[s]--;
      return e;
   endfunction

   // Moves the ring front to the tail, or drops it when keep is clear.
   function automatic int rotate_ring(bit keep);
      int s;
      s = rotation[rot_front];
      if (keep) rotation[(rot_front + rot_size) % PATH_SLOTS] = s;
      else rot_size--;
      rot_front = (rot_front + 1) % PATH_SLOTS;
      return s;
   endfunction

   function automatic void expect_result(logic [EVENT_W-1:0] ev, logic [31:0] e, logic last);
      outcome_type o;
      o.ev = ev;
      o.msg = e[31:16];
      o.rtr = e[15:0];
      o.last = last;
      awaited_results.push_back(o);
   endfunction

   // Works out the results of one accepted request and updates the model.
   function automatic void schedule_request(request_type r);
      int s, f, lim, cap, sent, idle, laps, rs;
      bit purged;
      logic [31:0] entry;
      entry = {r.msg, r.rtr};
      case (r.kind)
         KIND_ENQUEUE: begin
            s = lookup_path(r.tag);
            if (s < 0) begin
               for (f = 1; f < PATH_SLOTS; f++)
                  if (!path_live[f]) break;
               if (f >= PATH_SLOTS) begin
                  expect_result(EVENT_REJECT, entry, 1'b1);
                  return;
               end
               s = f;
               path_live[s] = 1;
               path_tag_of[s] = r.tag;
               backlog_head[s] = 0;
               backlog_len[s] = 0;
               drop_pending[s] = 0;
               rotation[(rot_front + rot_size) % PATH_SLOTS] = s;
               rot_size++;
            end
            lim = length_limit;
            if (lim == 0) lim = 1;
            if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
            if (backlog_len[s] >= lim) void'(pop_backlog(s));
            backlog[s][(backlog_head[s] + backlog_len[s]) % QUEUE_DEPTH] = entry;
            backlog_len[s]++;
         end
         KIND_REMOVE: begin
            s = lookup_path(r.tag);
            if (s >= 0) drop_pending[s] = 1;
         end
         KIND_TICK: begin
            purged = 0;
            for (s = 0; s < PATH_SLOTS; s++) begin
               if (!drop_pending[s]) continue;
               drop_pending[s] = 0;
               purged = 1;
               backlog_head[s] = 0;
               backlog_len[s] = 0;
               if (s != 0) begin
                  path_live[s] = 0;
                  path_tag_of[s] = '0;
               end
            end
            if (purged) begin
               laps = rot_size;
               for (int i = 0; i < laps; i++)
                  void'(rotate_ring(path_live[rotation[rot_front]]));
            end
            while (backlog_len[0] > 0)
               expect_result(EVENT_SEND, pop_backlog(0), 1'b0);
            cap = (sends_per_tick > SEND_CAP) ? SEND_CAP : sends_per_tick;
            sent = 0;
            idle = 0;
            if (rot_size > 0) begin
               while (sent < cap) begin
                  rs = rotate_ring(1'b1);
                  if (backlog_len[rs] > 0) begin
                     expect_result(EVENT_SEND, pop_backlog(rs), 1'b0);
                     sent++;
                     idle = 0;
                  end else begin
                     idle++;
                  end
                  if (idle == rot_size) break;
               end
            end
            expect_result(EVENT_DONE, 32'h0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Driver: presents the next request, holds it until accepted, then
   // leaves the gap that the request carries.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            schedule_request(cur);
            accepted++;
         end
         if (start && cur.gap > 0) begin
            gap_left <= cur.gap - 1;
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_requests.size() > 0 &&
                      !(pending_requests[0].drain &&
                        (awaited_results.size() > 0 || busy))) begin
            cur = pending_requests.pop_front();
            req_kind <= cur.kind;
            req_path_tag <= cur.tag;
            req_message_handle <= cur.msg;
            req_router_handle <= cur.rtr;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is one result and must match the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result ev=%0d msg=%h rtr=%h last=%b", $time,
                     rsp_event_res, rsp_message_handle_res, rsp_router_handle_res, rsp_last);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_event_res == EVENT_REJECT) rejects_seen++;
            if (rsp_event_res == EVENT_DONE) ticks_seen++;
            if (rsp_event_res !== want.ev) begin
               errors++;
               $display("%0t: event expected %0d actual %0d", $time, want.ev, rsp_event_res);
            end
            if (rsp_message_handle_res !== want.msg) begin
               errors++;
               $display("%0t: message handle expected %h actual %h", $time, want.msg,
                        rsp_message_handle_res);
            end
            if (rsp_router_handle_res !== want.rtr) begin
               errors++;
               $display("%0t: router handle expected %h actual %h", $time, want.rtr,
                        rsp_router_handle_res);
            end
            if (rsp_last !== want.last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Gaps are mostly zero, sometimes short and rarely long.
   function automatic int pick_gap(bit busy_phase);
      int p;
      if (busy_phase) return 0;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic add_request(logic [KIND_W-1:0] kind, logic [TAG_BITS-1:0] tag,
                              logic [HANDLE_W-1:0] msg, logic [HANDLE_W-1:0] rtr,
                              bit drain = 0, bit no_gap = 0);
      request_type r;
      r.kind = kind;
      r.tag = tag;
      r.msg = msg;
      r.rtr = rtr;
      r.drain = drain;
      r.gap = pick_gap(no_gap);
      pending_requests.push_back(r);
   endtask

   // Waits until the block has finished everything, including requests
   // that produce no result.
   task automatic wait_idle();
      while (pending_requests.size() > 0 || start || gap_left > 0 ||
             awaited_results.size() > 0 || busy)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_DATA_W-1:0];
      if (idx == CSR_MAX_SENDS) sends_per_tick = value & 6'h3f;
      else length_limit = value & 4'hf;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Most traffic goes to a small pool of tags so that paths fill, get
   // removed and come back; a few requests carry fully random tags.
   task automatic random_phase(int count);
      int p;
      bit quiet;
      logic [TAG_BITS-1:0] tag;
      logic [HANDLE_W-1:0] m;
      logic [HANDLE_W-1:0] rt;
      quiet = $urandom_range(1);
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(99);
         tag = ($urandom_range(9) == 0) ? $urandom() : tag_pool[$urandom_range(23)];
         m = HANDLE_W'($urandom());
         rt = HANDLE_W'($urandom());
         if (p < 55) add_request(KIND_ENQUEUE, tag, m, rt, 0, quiet);
         else if (p < 67) add_request(KIND_REMOVE, tag, m, rt, 0, quiet);
         else if (p < 96) add_request(KIND_TICK, tag, m, rt, 0, quiet);
         else add_request(KIND_UNUSED, tag, m, rt, 0, quiet);
         if (i == count / 2) quiet = !quiet;
      end
      add_request(KIND_TICK, '0, '0, '0);
   endtask

   initial begin
      path_live[0] = 1;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 24; i++) tag_pool[i] = $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: handle extremes on the priority
      // path, an all-ones tag, removal of the priority path and of an
      // unknown path, the unused kind, and a full path table.
      add_request(KIND_ENQUEUE, '0, 16'h0000, 16'hffff);
      add_request(KIND_ENQUEUE, '0, 16'hffff, 16'h0000);
      add_request(KIND_ENQUEUE, '1, 16'h1234, 16'habcd);
      add_request(KIND_TICK, '0, '0, '0);
      add_request(KIND_TICK, '0, '0, '0);
      add_request(KIND_ENQUEUE, '0, 16'h5555, 16'haaaa);
      add_request(KIND_REMOVE, '0, '0, '0);
      add_request(KIND_REMOVE, 32'h0bad_f00d, '0, '0);
      add_request(KIND_UNUSED, '1, '1, '1);
      add_request(KIND_TICK, '0, '0, '0);
      for (int i = 0; i < 15; i++)
         add_request(KIND_ENQUEUE, tag_pool[i + 2], HANDLE_W'($urandom()),
                     HANDLE_W'($urandom()));
      add_request(KIND_TICK, '0, '0, '0);
      // The sender holds off here until the backlog of results is gone.
      add_request(KIND_REMOVE, '1, '0, '0, 1);
      add_request(KIND_TICK, '0, '0, '0);
      random_phase(15);
      wait_idle();

      write_register(CSR_MAX_SENDS, 1);
      write_register(CSR_QUEUE_LIMIT, 1);
      random_phase(20);
      wait_idle();
      write_register(CSR_MAX_SENDS, 63);
      write_register(CSR_QUEUE_LIMIT, 15);
      random_phase(25);
      wait_idle();
      write_register(CSR_MAX_SENDS, 0);
      write_register(CSR_QUEUE_LIMIT, 0);
      random_phase(15);
      wait_idle();
      write_register(CSR_MAX_SENDS, 32);
      write_register(CSR_QUEUE_LIMIT, 3);
      random_phase(25);
      wait_idle();
      write_register(CSR_MAX_SENDS, $urandom_range(31, 2));
      write_register(CSR_QUEUE_LIMIT, $urandom_range(8, 1));
      random_phase(30);
      wait_idle();

      $display("Run covered %0d requests over six register settings.", accepted);
      $display("Checked %0d results: %0d ticks done, %0d rejects.", results_seen,
               ticks_seen, rejects_seen);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* per_path_round_robin_send_scheduler.f */
+incdir+design
design/ppsrr_pkg.sv
design/ppsrr_front.sv
design/ppsrr_back.sv
design/per_path_round_robin_send_scheduler.sv
tb/tb.sv
